// ===== sv/jtvc_pkg.sv =====
// ----------------------------------------------------------------------------
// jtvc_pkg
// Shared types, codes and helpers of the release tag version checker.
// ----------------------------------------------------------------------------
package jtvc_pkg;

    // Value length limit and version part width
    localparam int TAG_CAPACITY = 64;
    localparam int VALUE_LIMIT  = TAG_CAPACITY - 1;
    localparam int COUNT_W      = $clog2(TAG_CAPACITY);
    localparam int VERSION_BITS = 16;
    localparam int ACC_W        = VERSION_BITS + 4;

    // Release key is matched as ten stored bytes plus the current one
    localparam int KEY_LEN = 11;
    localparam int WIN_LEN = KEY_LEN - 1;
    localparam logic [7:0] KEY_PATTERN [KEY_LEN] = '{
        8'h22, 8'h74, 8'h61, 8'h67, 8'h5F, 8'h6E, 8'h61, 8'h6D, 8'h65, 8'h22, 8'h3A
    };

    // Character codes
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_V   = 8'h76;
    localparam logic [7:0] CH_UPPER_V   = 8'h56;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_CURRENT_MAJOR  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CURRENT_MINOR  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CURRENT_PATCH  = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CHECK_DISABLED = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DISABLED   = 2'd0;
    localparam logic [1:0] ST_PARSE_ERR  = 2'd1;
    localparam logic [1:0] ST_NEW        = 2'd2;
    localparam logic [1:0] ST_UP_TO_DATE = 2'd3;

    typedef enum logic [2:0] {
        SP_SEARCH,
        SP_BLANKS,
        SP_VALUE,
        SP_ESCAPE,
        SP_ENDED,
        SP_FAILED
    } scan_phase_t;

    typedef enum logic [2:0] {
        VP_PREFIX,
        VP_MAJOR,
        VP_MINOR,
        VP_PATCH,
        VP_STOP
    } version_phase_t;

    // One classified beat handed from front to back
    typedef struct packed {
        logic       emit;      // value character present
        logic [7:0] char_byte; // unescaped value character
        logic       last;      // final beat of the body
        logic       value_ok;  // a value was opened before the end
    } jtvc_item_t;

    // Append one decimal digit, saturating at the all-ones value
    function automatic logic [VERSION_BITS-1:0] add_digit(
        input logic [VERSION_BITS-1:0] acc,
        input logic [3:0]              d
    );
        logic [ACC_W-1:0] wide;
        logic [ACC_W-1:0] n;
        wide = {4'b0, acc};
        n = (wide << 3) + (wide << 1) + {{(ACC_W-4){1'b0}}, d};
        if (n > {4'b0, {VERSION_BITS{1'b1}}}) begin
            return {VERSION_BITS{1'b1}};
        end
        return n[VERSION_BITS-1:0];
    endfunction

endpackage

// ===== sv/jtvc_front.sv =====
// ----------------------------------------------------------------------------
// jtvc_front
// Key search, blank skipping and value unescaping, one beat per cycle while beat_accept is high.
// ----------------------------------------------------------------------------
module jtvc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                beat_accept,
    input  logic [7:0]          body_byte,
    input  logic                body_last,
    output logic                push,
    output jtvc_pkg::jtvc_item_t push_item
);

    logic [7:0]                   window_reg [jtvc_pkg::WIN_LEN];
    jtvc_pkg::scan_phase_t        phase_reg;
    jtvc_pkg::scan_phase_t        phase_next;
    logic [jtvc_pkg::COUNT_W-1:0] count_reg;
    logic                         key_hit;
    logic                         emit;
    logic [7:0]                   emit_char;
    logic                         value_ok;

    // Match the window and the current byte against the key
    always_comb begin
        key_hit = (body_byte == jtvc_pkg::KEY_PATTERN[jtvc_pkg::KEY_LEN-1]);
        for (int i = 0; i < jtvc_pkg::WIN_LEN; i++) begin
            if (window_reg[i] != jtvc_pkg::KEY_PATTERN[i]) begin
                key_hit = 1'b0;
            end
        end
    end

    // Outputs: value character and its unescaped code
    always_comb begin
        emit      = 1'b0;
        emit_char = body_byte;
        unique case (phase_reg)
            jtvc_pkg::SP_VALUE: begin
                emit = (body_byte != jtvc_pkg::CH_QUOTE) &&
                       !((body_byte == jtvc_pkg::CH_BACKSLASH) && !body_last);
            end
            jtvc_pkg::SP_ESCAPE: begin
                emit = 1'b1;
                priority if (body_byte == jtvc_pkg::CH_LOWER_N) begin
                    emit_char = jtvc_pkg::CH_LF;
                end else if (body_byte == jtvc_pkg::CH_LOWER_T) begin
                    emit_char = jtvc_pkg::CH_TAB;
                end else if (body_byte == jtvc_pkg::CH_LOWER_R) begin
                    emit_char = jtvc_pkg::CH_CR;
                end else begin
                    emit_char = body_byte;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Next scan phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            jtvc_pkg::SP_SEARCH: begin
                if (key_hit) begin
                    phase_next = jtvc_pkg::SP_BLANKS;
                end
            end
            jtvc_pkg::SP_BLANKS: begin
                if (body_byte == jtvc_pkg::CH_QUOTE) begin
                    phase_next = jtvc_pkg::SP_VALUE;
                end else if (body_byte != jtvc_pkg::CH_SPACE &&
                             body_byte != jtvc_pkg::CH_TAB) begin
                    phase_next = jtvc_pkg::SP_FAILED;
                end
            end
            jtvc_pkg::SP_VALUE: begin
                if (body_byte == jtvc_pkg::CH_QUOTE) begin
                    phase_next = jtvc_pkg::SP_ENDED;
                end else if (body_byte == jtvc_pkg::CH_BACKSLASH && !body_last) begin
                    phase_next = jtvc_pkg::SP_ESCAPE;
                end
            end
            jtvc_pkg::SP_ESCAPE: begin
                phase_next = jtvc_pkg::SP_VALUE;
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
        // Close the value once it reaches its length limit
        if (emit && (count_reg >= jtvc_pkg::COUNT_W'(jtvc_pkg::VALUE_LIMIT - 1))) begin
            phase_next = jtvc_pkg::SP_ENDED;
        end
    end

    assign value_ok = (phase_next == jtvc_pkg::SP_VALUE) ||
                      (phase_next == jtvc_pkg::SP_ESCAPE) ||
                      (phase_next == jtvc_pkg::SP_ENDED);

    // Forward only beats that carry a character or end the body
    assign push                = beat_accept && (emit || body_last);
    assign push_item.emit      = emit;
    assign push_item.char_byte = emit_char;
    assign push_item.last      = body_last;
    assign push_item.value_ok  = value_ok;

    // Advance scan state; return to reset after the last beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= jtvc_pkg::SP_SEARCH;
            count_reg <= '0;
            for (int i = 0; i < jtvc_pkg::WIN_LEN; i++) begin
                window_reg[i] <= 8'h00;
            end
        end else if (beat_accept) begin
            if (body_last) begin
                phase_reg <= jtvc_pkg::SP_SEARCH;
                count_reg <= '0;
                for (int i = 0; i < jtvc_pkg::WIN_LEN; i++) begin
                    window_reg[i] <= 8'h00;
                end
            end else begin
                phase_reg <= phase_next;
                count_reg <= count_reg + jtvc_pkg::COUNT_W'(emit);
                for (int i = 0; i < jtvc_pkg::WIN_LEN - 1; i++) begin
                    window_reg[i] <= window_reg[i+1];
                end
                window_reg[jtvc_pkg::WIN_LEN-1] <= body_byte;
            end
        end
    end

endmodule

// ===== sv/jtvc_queue.sv =====
// ----------------------------------------------------------------------------
// jtvc_queue
// Short queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module jtvc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  jtvc_pkg::jtvc_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 pop_valid,
    output jtvc_pkg::jtvc_item_t pop_item
);

    jtvc_pkg::jtvc_item_t        entry_reg [jtvc_pkg::QUEUE_DEPTH];
    logic [jtvc_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [jtvc_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [jtvc_pkg::QCNT_W-1:0] count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign full      = (count_reg == jtvc_pkg::QCNT_W'(jtvc_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Store pushed beats
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == jtvc_pkg::QPTR_W'(jtvc_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == jtvc_pkg::QPTR_W'(jtvc_pkg::QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + jtvc_pkg::QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - jtvc_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

// ===== sv/jtvc_back.sv =====
// ----------------------------------------------------------------------------
// jtvc_back
// Version parsing, comparison against the running version and result output.
// ----------------------------------------------------------------------------
module jtvc_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [jtvc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [jtvc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             pop_valid,
    input  jtvc_pkg::jtvc_item_t             pop_item,
    output logic                             pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       check_status,
    output logic [jtvc_pkg::VERSION_BITS-1:0] tag_major,
    output logic [jtvc_pkg::VERSION_BITS-1:0] tag_minor,
    output logic [jtvc_pkg::VERSION_BITS-1:0] tag_patch
);

    logic [jtvc_pkg::VERSION_BITS-1:0] cur_major_reg;
    logic [jtvc_pkg::VERSION_BITS-1:0] cur_minor_reg;
    logic [jtvc_pkg::VERSION_BITS-1:0] cur_patch_reg;
    logic                              disabled_reg;

    jtvc_pkg::version_phase_t vphase_reg;
    jtvc_pkg::version_phase_t vphase_next;
    jtvc_pkg::version_phase_t vphase_eff;
    logic [jtvc_pkg::VERSION_BITS-1:0] major_reg, major_next;
    logic [jtvc_pkg::VERSION_BITS-1:0] minor_reg, minor_next;
    logic [jtvc_pkg::VERSION_BITS-1:0] patch_reg, patch_next;

    logic                              m_valid_reg;
    logic [1:0]                        status_reg;
    logic [jtvc_pkg::VERSION_BITS-1:0] out_major_reg, out_minor_reg, out_patch_reg;

    logic          out_free;
    logic          feed;
    logic          prefix_v;
    logic          is_digit;
    logic [3:0]    digit;
    logic          newer;
    logic [1:0]    status_next;
    logic          finish;

    // Take a beat unless it ends the body and the result slot is busy
    assign out_free = !m_valid_reg || m_ready;
    assign pop      = pop_valid && (!pop_item.last || out_free);
    assign feed     = pop && pop_item.emit;
    assign finish   = pop && pop_item.last;

    assign is_digit = (pop_item.char_byte >= jtvc_pkg::CH_ZERO) &&
                      (pop_item.char_byte <= jtvc_pkg::CH_NINE);
    assign digit    = 4'(pop_item.char_byte - jtvc_pkg::CH_ZERO);
    assign vphase_eff = (vphase_reg == jtvc_pkg::VP_PREFIX) ? jtvc_pkg::VP_MAJOR : vphase_reg;
    assign prefix_v = (vphase_reg == jtvc_pkg::VP_PREFIX) &&
                      (pop_item.char_byte == jtvc_pkg::CH_LOWER_V ||
                       pop_item.char_byte == jtvc_pkg::CH_UPPER_V);

    // Next parser phase
    always_comb begin
        vphase_next = vphase_reg;
        if (feed) begin
            vphase_next = vphase_eff;
            if (!prefix_v && !is_digit) begin
                unique case (vphase_eff)
                    jtvc_pkg::VP_MAJOR: begin
                        vphase_next = (pop_item.char_byte == jtvc_pkg::CH_DOT) ?
                                      jtvc_pkg::VP_MINOR : jtvc_pkg::VP_STOP;
                    end
                    jtvc_pkg::VP_MINOR: begin
                        vphase_next = (pop_item.char_byte == jtvc_pkg::CH_DOT) ?
                                      jtvc_pkg::VP_PATCH : jtvc_pkg::VP_STOP;
                    end
                    jtvc_pkg::VP_PATCH: begin
                        vphase_next = jtvc_pkg::VP_STOP;
                    end
                    default: begin
                        vphase_next = vphase_eff;
                    end
                endcase
            end
        end
    end

    // Accumulate digits into the active part
    always_comb begin
        major_next = major_reg;
        minor_next = minor_reg;
        patch_next = patch_reg;
        if (feed && !prefix_v && is_digit) begin
            unique case (vphase_eff)
                jtvc_pkg::VP_MAJOR: major_next = jtvc_pkg::add_digit(major_reg, digit);
                jtvc_pkg::VP_MINOR: minor_next = jtvc_pkg::add_digit(minor_reg, digit);
                jtvc_pkg::VP_PATCH: patch_next = jtvc_pkg::add_digit(patch_reg, digit);
                default: begin
                    major_next = major_reg;
                end
            endcase
        end
    end

    // Compare the tag against the running version
    always_comb begin
        if (major_next != cur_major_reg) begin
            newer = major_next > cur_major_reg;
        end else if (minor_next != cur_minor_reg) begin
            newer = minor_next > cur_minor_reg;
        end else begin
            newer = patch_next > cur_patch_reg;
        end
        priority if (disabled_reg) begin
            status_next = jtvc_pkg::ST_DISABLED;
        end else if (!pop_item.value_ok) begin
            status_next = jtvc_pkg::ST_PARSE_ERR;
        end else if (newer) begin
            status_next = jtvc_pkg::ST_NEW;
        end else begin
            status_next = jtvc_pkg::ST_UP_TO_DATE;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_major_reg <= '0;
            cur_minor_reg <= '0;
            cur_patch_reg <= '0;
            disabled_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                jtvc_pkg::CFG_CURRENT_MAJOR:
                    cur_major_reg <= cfg_wdata[jtvc_pkg::VERSION_BITS-1:0];
                jtvc_pkg::CFG_CURRENT_MINOR:
                    cur_minor_reg <= cfg_wdata[jtvc_pkg::VERSION_BITS-1:0];
                jtvc_pkg::CFG_CURRENT_PATCH:
                    cur_patch_reg <= cfg_wdata[jtvc_pkg::VERSION_BITS-1:0];
                jtvc_pkg::CFG_CHECK_DISABLED:
                    disabled_reg  <= cfg_wdata[0];
            endcase
        end
    end

    // Advance parser state; clear it once a body ends
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vphase_reg <= jtvc_pkg::VP_PREFIX;
            major_reg  <= '0;
            minor_reg  <= '0;
            patch_reg  <= '0;
        end else if (finish) begin
            vphase_reg <= jtvc_pkg::VP_PREFIX;
            major_reg  <= '0;
            minor_reg  <= '0;
            patch_reg  <= '0;
        end else begin
            vphase_reg <= vphase_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
            patch_reg  <= patch_next;
        end
    end

    // Hold the result beat until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            status_reg <= status_next;
            if (status_next == jtvc_pkg::ST_DISABLED || status_next == jtvc_pkg::ST_PARSE_ERR) begin
                out_major_reg <= '0;
                out_minor_reg <= '0;
                out_patch_reg <= '0;
            end else begin
                out_major_reg <= major_next;
                out_minor_reg <= minor_next;
                out_patch_reg <= patch_next;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign check_status = status_reg;
    assign tag_major    = out_major_reg;
    assign tag_minor    = out_minor_reg;
    assign tag_patch    = out_patch_reg;

endmodule

// ===== sv/json_tag_version_check.sv =====
// ----------------------------------------------------------------------------
// json_tag_version_check
// Release tag extraction from a message body and comparison with the running
// version.
// ----------------------------------------------------------------------------
// Usage:
//   The body streams in on the s_ channel, one byte per beat, with s_tlast on
//   the final byte. One result beat leaves on the m_ channel per body, after
//   its last byte: status, then major, minor and patch of the tag.
//   The running version and the disable flag are set through cfg_we,
//   cfg_addr and cfg_wdata while no body is in flight.
// Throughput and flow:
//   One byte per cycle while s_tready is high; the key window compare and
//   the digit accumulate each sit in their own stage. The result beat
//   becomes valid after the last byte is accepted: the queue registers the
//   beat, then the back part loads the output register.
// Reset:
//   aresetn low clears the scan and parse state, the queue, the result slot
//   and the configuration registers; s_tready goes high at a reset clock
//   edge, as the queue comes out empty.
// Stall:
//   A waiting result holds in the output register; the back part keeps
//   parsing the next body and only stalls at its last byte, and the
//   two-beat queue then drops s_tready once it fills.
// ----------------------------------------------------------------------------
module json_tag_version_check (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [jtvc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [jtvc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Body input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] body_byte
    input  logic                            s_tlast,  // body_last
    // Result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [55:0]                     m_tdata   // [1:0] check_status,
                                                      // [17:2] tag_major,
                                                      // [33:18] tag_minor,
                                                      // [49:34] tag_patch
);

    jtvc_pkg::jtvc_item_t push_item;
    jtvc_pkg::jtvc_item_t pop_item;
    logic push;
    logic full;
    logic pop;
    logic pop_valid;
    logic beat_accept;
    logic [1:0] check_status;
    logic [jtvc_pkg::VERSION_BITS-1:0] tag_major;
    logic [jtvc_pkg::VERSION_BITS-1:0] tag_minor;
    logic [jtvc_pkg::VERSION_BITS-1:0] tag_patch;

    assign s_tready    = !full;
    assign beat_accept = s_tvalid && s_tready;

    jtvc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .beat_accept (beat_accept),
        .body_byte   (s_tdata),
        .body_last   (s_tlast),
        .push        (push),
        .push_item   (push_item)
    );

    jtvc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    jtvc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .pop_valid    (pop_valid),
        .pop_item     (pop_item),
        .pop          (pop),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .check_status (check_status),
        .tag_major    (tag_major),
        .tag_minor    (tag_minor),
        .tag_patch    (tag_patch)
    );

    // Pack the result beat, zero padded to whole bytes
    assign m_tdata = {6'b0, tag_patch, tag_minor, tag_major, check_status};

endmodule

// ===== dv/jtvc_checker.sv =====
// ----------------------------------------------------------------------------
// jtvc_checker
// Watches the body, result and configuration ports of the tag version
// checker. It keeps its own model of the key search, the value unescaping and
// the version parse, queues one expected result per body and compares every
// result beat field by field with the oldest one.
// ----------------------------------------------------------------------------
module jtvc_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [jtvc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [jtvc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] body_byte
    input  logic                            s_tlast,  // body_last
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [55:0]                     m_tdata,  // [1:0] check_status,
                                                      // [17:2] tag_major,
                                                      // [33:18] tag_minor,
                                                      // [49:34] tag_patch
    output int unsigned                     fail_count,
    output int unsigned                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import jtvc_pkg::*;

    // Key as it sits in the window plus the current byte, oldest byte on top
    localparam logic [87:0] KEY_WORD   = {
        KEY_PATTERN[0], KEY_PATTERN[1], KEY_PATTERN[2], KEY_PATTERN[3],
        KEY_PATTERN[4], KEY_PATTERN[5], KEY_PATTERN[6], KEY_PATTERN[7],
        KEY_PATTERN[8], KEY_PATTERN[9], KEY_PATTERN[10]
    };
    localparam int unsigned VALUE_ROOM = VALUE_LIMIT;
    localparam int unsigned MAX_PRINTS = 40;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] major;
        logic [15:0] minor;
        logic [15:0] patch;
    } tag_report_t;

    tag_report_t    pending_reports [$];
    tag_report_t    want;

    // Running version copy
    logic [15:0]    cur_major;
    logic [15:0]    cur_minor;
    logic [15:0]    cur_patch;
    logic           check_off;

    // Per-body parse state
    logic [79:0]    recent;
    scan_phase_t    scan;
    version_phase_t vphase;
    int unsigned    value_len;
    logic [15:0]    acc_major;
    logic [15:0]    acc_minor;
    logic [15:0]    acc_patch;

    initial fail_count = 0;

    task automatic flag_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
        if (fail_count < MAX_PRINTS) begin
            $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, exp_val);
        end
        fail_count++;
    endtask

    function automatic void clear_body();
        recent    = '0;
        scan      = SP_SEARCH;
        vphase    = VP_PREFIX;
        value_len = 0;
        acc_major = '0;
        acc_minor = '0;
        acc_patch = '0;
    endfunction

    // Shift one decimal digit in, clamp at all ones
    function automatic logic [15:0] push_digit(input logic [15:0] acc,
                                               input logic [7:0] c);
        int unsigned n;
        n = int'(acc) * 10 + int'(c) - int'(CH_ZERO);
        return (n > 32'hFFFF) ? 16'hFFFF : n[15:0];
    endfunction

    // Feed one unescaped value character to the version parse
    function automatic void parse_version_char(input logic [7:0] c);
        logic digit;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (vphase == VP_PREFIX) begin
            vphase = VP_MAJOR;
            if (c == CH_LOWER_V || c == CH_UPPER_V) begin
                return;
            end
        end
        case (vphase)
            VP_MAJOR: begin
                if (digit) acc_major = push_digit(acc_major, c);
                else vphase = (c == CH_DOT) ? VP_MINOR : VP_STOP;
            end
            VP_MINOR: begin
                if (digit) acc_minor = push_digit(acc_minor, c);
                else vphase = (c == CH_DOT) ? VP_PATCH : VP_STOP;
            end
            VP_PATCH: begin
                if (digit) acc_patch = push_digit(acc_patch, c);
                else vphase = VP_STOP;
            end
            default: ;
        endcase
    endfunction

    function automatic void take_value_char(input logic [7:0] c);
        parse_version_char(c);
        value_len++;
        if (value_len >= VALUE_ROOM) begin
            scan = SP_ENDED;
        end
    endfunction

    // Advance the model by one body beat; queue a result on the last one
    function automatic void absorb_body_byte(input logic [7:0] b, input logic last);
        tag_report_t rep;
        logic [7:0]  c;
        case (scan)
            SP_SEARCH: begin
                if ({recent, b} == KEY_WORD) scan = SP_BLANKS;
            end
            SP_BLANKS: begin
                if (b == CH_QUOTE) scan = SP_VALUE;
                else if (b != CH_SPACE && b != CH_TAB) scan = SP_FAILED;
            end
            SP_VALUE: begin
                if (b == CH_QUOTE) scan = SP_ENDED;
                else if (b == CH_BACKSLASH && !last) scan = SP_ESCAPE;
                else take_value_char(b);
            end
            SP_ESCAPE: begin
                case (b)
                    CH_LOWER_N: c = CH_LF;
                    CH_LOWER_T: c = CH_TAB;
                    CH_LOWER_R: c = CH_CR;
                    default:    c = b;
                endcase
                scan = SP_VALUE;
                take_value_char(c);
            end
            default: ;
        endcase
        recent = {recent[71:0], b};

        if (last) begin
            rep = '{status: ST_PARSE_ERR, major: '0, minor: '0, patch: '0};
            if (check_off) begin
                rep.status = ST_DISABLED;
            end else if (scan == SP_VALUE || scan == SP_ESCAPE || scan == SP_ENDED) begin
                rep.major  = acc_major;
                rep.minor  = acc_minor;
                rep.patch  = acc_patch;
                rep.status = ({acc_major, acc_minor, acc_patch} >
                              {cur_major, cur_minor, cur_patch}) ? ST_NEW : ST_UP_TO_DATE;
            end
            pending_reports.push_back(rep);
            clear_body();
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_body();
            cur_major = '0;
            cur_minor = '0;
            cur_patch = '0;
            check_off = 1'b0;
            pending_reports.delete();
        end else begin
            // Compare each result beat with the oldest expectation
            if (m_tvalid && m_tready) begin
                if (pending_reports.size() == 0) begin
                    flag_mismatch("result beat with nothing expected, status",
                                  16'(m_tdata[1:0]), 16'd0);
                end else begin
                    want = pending_reports.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        flag_mismatch("check_status", 16'(m_tdata[1:0]), 16'(want.status));
                    if (m_tdata[17:2] !== want.major)
                        flag_mismatch("tag_major", m_tdata[17:2], want.major);
                    if (m_tdata[33:18] !== want.minor)
                        flag_mismatch("tag_minor", m_tdata[33:18], want.minor);
                    if (m_tdata[49:34] !== want.patch)
                        flag_mismatch("tag_patch", m_tdata[49:34], want.patch);
                end
            end

            // Run accepted body beats through the model
            if (s_tvalid && s_tready) begin
                absorb_body_byte(s_tdata, s_tlast);
            end

            // Track register writes
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_CURRENT_MAJOR:  cur_major = cfg_wdata;
                    CFG_CURRENT_MINOR:  cur_minor = cfg_wdata;
                    CFG_CURRENT_PATCH:  cur_patch = cfg_wdata;
                    CFG_CHECK_DISABLED: check_off = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        outstanding <= pending_reports.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the tag version checker. Streams directed and
// random message bodies with random gaps on both channels, steps through
// several running versions and the disable flag, and holds the result
// channel off once long enough to back the block up to its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jtvc_pkg::*;

    // Body beats of the whole run, directed ones included
    localparam int unsigned TOTAL_BEATS = 680;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [55:0]           m_tdata;

    int unsigned           fail_count;
    int unsigned           outstanding;

    // Stimulus bookkeeping
    logic [7:0]            body_q [$];
    int unsigned           beats_sent = 0;
    bit                    tx_steady  = 1'b0;
    logic                  choke_go   = 1'b0;
    logic [15:0]           run_major;
    logic [15:0]           run_minor;
    logic [15:0]           run_patch;

    always #6 aclk = ~aclk;

    json_tag_version_check u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    jtvc_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void add_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            body_q.push_back(t[i]);
        end
    endfunction

    // Append the first n bytes of the release key
    function automatic void add_key(input int n);
        for (int i = 0; i < n; i++) begin
            body_q.push_back(KEY_PATTERN[i]);
        end
    endfunction

    function automatic void add_noise(input int unsigned n);
        repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Value character, sometimes behind a redundant backslash
    function automatic void add_value_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            if ($urandom_range(0, 15) == 0) body_q.push_back(CH_BACKSLASH);
            body_q.push_back(t[i]);
        end
    endfunction

    // Version part near the running one, small, or past saturation
    function automatic int unsigned pick_part(input logic [15:0] cur);
        case ($urandom_range(0, 5))
            0: return cur;
            1: return int'(cur) + 1;
            2: return (cur == 0) ? 0 : int'(cur) - 1;
            3: return $urandom_range(0, 9);
            4: return $urandom_range(0, 99999);
            default: return $urandom_range(0, 999);
        endcase
    endfunction

    // Build one random body: mostly well formed, some broken, some noise
    function automatic void make_body();
        int unsigned kind;
        string       ver;
        logic [7:0]  bad;
        kind = $urandom_range(0, 99);
        add_noise($urandom_range(0, 6));
        if (kind < 15) begin
            add_noise($urandom_range(1, 20));
            return;
        end
        if (kind < 27) begin
            case ($urandom_range(0, 2))
                0: begin
                    // truncated key
                    add_key(KEY_LEN);
                    repeat ($urandom_range(1, 10)) void'(body_q.pop_back());
                    add_noise($urandom_range(0, 5));
                end
                1: begin
                    // stray byte between key and value
                    bad = 8'($urandom_range(0, 255));
                    if (bad == CH_SPACE || bad == CH_TAB || bad == CH_QUOTE) bad = CH_DOT;
                    add_key(KEY_LEN);
                    add_text(" ");
                    body_q.push_back(bad);
                    add_text("\"1.2.3\"");
                end
                default: begin
                    // body ends among the blanks
                    add_key(KEY_LEN);
                    repeat ($urandom_range(0, 3)) body_q.push_back(CH_SPACE);
                    body_q.push_back(CH_TAB);
                end
            endcase
            return;
        end

        add_key(KEY_LEN);
        repeat ($urandom_range(0, 3)) begin
            body_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        end
        body_q.push_back(CH_QUOTE);
        case ($urandom_range(0, 5))
            0: ver = $sformatf("%0d", pick_part(run_major));
            1: ver = $sformatf("%0d.%0d", pick_part(run_major), pick_part(run_minor));
            default: ver = $sformatf("%0d.%0d.%0d", pick_part(run_major),
                                     pick_part(run_minor), pick_part(run_patch));
        endcase
        case ($urandom_range(0, 7))
            0: ver = {"v", ver};
            1: ver = {"V", ver};
            2: ver = {ver, "-rc1"};
            default: ;
        endcase
        add_value_text(ver);
        // Occasionally run past the value capacity
        if ($urandom_range(0, 24) == 0) begin
            repeat ($urandom_range(55, 70)) body_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 9) != 0) body_q.push_back(CH_QUOTE);
        add_noise($urandom_range(0, 8));
    endfunction

    // Offer one beat, hold it until accepted, then maybe idle
    task automatic send_beat(input logic [7:0] b, input logic last);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        beats_sent++;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic ship_body();
        for (int i = 0; i < body_q.size(); i++) begin
            send_beat(body_q[i], i == body_q.size() - 1);
        end
        body_q.delete();
    endtask

    // Drop valid and wait until every expected result has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Write all four registers on consecutive cycles
    task automatic load_version(input logic [15:0] maj, input logic [15:0] mnr,
                                input logic [15:0] pat, input logic off);
        run_major = maj;
        run_minor = mnr;
        run_patch = pat;
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_CURRENT_MAJOR;
        cfg_wdata <= maj;
        @(posedge aclk);
        cfg_addr  <= CFG_CURRENT_MINOR;
        cfg_wdata <= mnr;
        @(posedge aclk);
        cfg_addr  <= CFG_CURRENT_PATCH;
        cfg_wdata <= pat;
        @(posedge aclk);
        cfg_addr  <= CFG_CHECK_DISABLED;
        cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, off};
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: random stalls, steady stretches and one long hold-off
    initial begin : rx_side
        int unsigned hold;
        int unsigned steady;
        bit          choke_done;
        steady     = 0;
        choke_done = 1'b0;
        m_tready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (choke_go && !choke_done) begin
                choke_done = 1'b1;
                hold = 500;
            end else if (steady > 0) begin
                steady--;
                hold = 0;
            end else begin
                hold = pick_gap();
                if ($urandom_range(0, 99) < 3) steady = $urandom_range(40, 150);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Stimulus
    initial begin : stim
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        run_major = '0;
        run_minor = '0;
        run_patch = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed bodies against running version 1.2.3
        load_version(16'd1, 16'd2, 16'd3, 1'b0);
        add_text("{"); add_key(KEY_LEN); add_text("\"v1.2.3\"}");     ship_body();
        add_key(KEY_LEN); add_text(" \t\"V2.0.0\",");                 ship_body();
        add_key(KEY_LEN); add_text("\"1.2.2\"");                      ship_body();
        // key on the last byte, end among blanks, stray byte after the key
        add_key(KEY_LEN);                                             ship_body();
        add_key(KEY_LEN); add_text(" \t");                            ship_body();
        add_key(KEY_LEN); add_text("x\"9.9.9\",");
        add_key(KEY_LEN); add_text("\"9.9.9\"");                      ship_body();
        // no key at all, single-byte bodies at both byte extremes
        add_text("no key here");                                      ship_body();
        body_q.push_back(8'h00);                                      ship_body();
        body_q.push_back(8'hFF);                                      ship_body();
        // trailing lone backslash, escaped quote, mapped escapes
        add_key(KEY_LEN); add_text("\"1.3\\");                        ship_body();
        add_key(KEY_LEN); add_text("\"1.2.\\\"4\"");                  ship_body();
        add_key(KEY_LEN); add_text("\"1\\.2\\.\\n4\"");               ship_body();
        add_key(KEY_LEN); add_text("\"\\t1\"");                       ship_body();
        add_key(KEY_LEN); add_text("\"2\\r\"");                       ship_body();
        // empty value, opening quote as the last byte
        add_key(KEY_LEN); add_text("\"\"");                           ship_body();
        add_key(KEY_LEN); add_text("\"");                             ship_body();
        // saturation and value capacity
        add_key(KEY_LEN); add_text("\"99999.70000.65536\"");          ship_body();
        add_key(KEY_LEN); add_text("\"1.2.");
        repeat (59) body_q.push_back(CH_ZERO);
        add_text("7\"");                                              ship_body();
        // zero byte stops the parse
        add_key(KEY_LEN); add_text("\"2.");
        body_q.push_back(8'h00);
        add_text("9\"");                                              ship_body();
        // unterminated value, later key ignored, key after a near miss
        add_key(KEY_LEN); add_text("\"3.4.5");                        ship_body();
        add_key(KEY_LEN); add_text("\"1.0.0\",");
        add_key(KEY_LEN); add_text("\"9.9.9\"");                      ship_body();
        add_key(KEY_LEN - 3); add_key(KEY_LEN); add_text("\"1.2.4\""); ship_body();

        // Running version at the low extreme
        drain();
        load_version(16'd0, 16'd0, 16'd0, 1'b0);
        add_key(KEY_LEN); add_text("\"0.0.0\"");                      ship_body();
        add_key(KEY_LEN); add_text("\"v0.0.1\"");                     ship_body();

        // Running version at the high extreme
        drain();
        load_version(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        add_key(KEY_LEN); add_text("\"99999.99999.99999\"");          ship_body();
        add_key(KEY_LEN); add_text("\"65535.65535.65534\"");          ship_body();

        // Check disabled
        drain();
        load_version(16'd1, 16'd2, 16'd3, 1'b1);
        add_key(KEY_LEN); add_text("\"9.9.9\"");                      ship_body();
        add_text("junk");                                             ship_body();

        drain();
        load_version(16'($urandom_range(0, 20)), 16'($urandom_range(0, 20)),
                     16'($urandom_range(0, 20)), 1'b0);

        // Hold the result side off while short bodies keep coming
        choke_go <= 1'b1;
        repeat (10) begin
            add_noise($urandom_range(1, 4));
            ship_body();
        end

        // Random bodies, with a fresh running version now and then
        while (beats_sent < TOTAL_BEATS) begin
            if ($urandom_range(0, 9) == 0) begin
                drain();
                case ($urandom_range(0, 4))
                    0: load_version(16'd0, 16'd0, 16'd0, $urandom_range(0, 9) == 0);
                    1: load_version(16'hFFFF, 16'hFFFF, 16'hFFFF, $urandom_range(0, 9) == 0);
                    2: load_version(16'($urandom), 16'($urandom), 16'($urandom),
                                    $urandom_range(0, 9) == 0);
                    default: load_version(16'($urandom_range(0, 12)),
                                          16'($urandom_range(0, 12)),
                                          16'($urandom_range(0, 12)),
                                          $urandom_range(0, 9) == 0);
                endcase
            end
            tx_steady = ($urandom_range(0, 4) == 0);
            make_body();
            ship_body();
        end

        drain();
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Give up if the run hangs
    initial begin : watchdog
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/jtvc_pkg.sv
sv/jtvc_front.sv
sv/jtvc_queue.sv
sv/jtvc_back.sv
sv/json_tag_version_check.sv
dv/jtvc_checker.sv
dv/tb_top.sv
